FILE: hw/rtl/pvts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pvts_pkg: shared types and constants of the counter-to-time scaler
// Register indexes, the configuration bundle and the item carried between
// the front and back halves of the datapath.
// -----------------------------------------------------------------------------
package pvts_pkg;

   localparam int unsigned COUNT_W   = 64;
   localparam int unsigned FRAC_W    = 32;
   localparam int unsigned SHIFT_W   = 7;
   localparam int unsigned FLAGS_W   = 8;
   localparam int unsigned CSR_IDX_W = 3;

   // Counter and reference time both run at eight times the system rate.
   localparam int unsigned RATE_SHIFT = 3;

   // Bit of clock_flags that marks the counter as stable across CPUs.
   localparam int unsigned STABLE_BIT = 0;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STAMP_VALUE    = 3'd0,
      CSR_REFERENCE_TIME = 3'd1,
      CSR_SCALE_FRACTION = 3'd2,
      CSR_SCALE_SHIFT    = 3'd3,
      CSR_CLOCK_FLAGS    = 3'd4,
      CSR_OFFSET_BASE    = 3'd5,
      CSR_SINGLE_CPU     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0]        stamp_value;
      logic [COUNT_W-1:0]        reference_time;
      logic [FRAC_W-1:0]         scale_fraction;
      logic signed [SHIFT_W-1:0] scale_shift;
      logic                      no_clamp;
      logic [COUNT_W-1:0]        offset_base;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] scaled;
      logic               behind;
   } front_item_type;

   typedef struct packed {
      logic push;
      logic full;
   } queue_ctl_type;

endpackage : pvts_pkg
`default_nettype wire

FILE: hw/rtl/pvts_front.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pvts_front: delta and pre-shift stages
// Takes counter readings, forms the scaled delta against the stamp and hands
// the result to the queue. Two register stages; holds while the queue is full.
// -----------------------------------------------------------------------------
module pvts_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire pvts_pkg::cfg_type       cfg,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire [pvts_pkg::COUNT_W-1:0]  in_reading,
   input  wire                          queue_full,
   output pvts_pkg::queue_ctl_type      queue_ctl,
   output pvts_pkg::front_item_type     queue_item
);
   import pvts_pkg::*;

   logic                 enable;
   logic                 d1_valid_ff, d1_valid_in;
   logic [COUNT_W-1:0]   d1_delta_ff, d1_delta_in;
   logic                 d1_behind_ff, d1_behind_in;
   logic                 d2_valid_ff, d2_valid_in;
   front_item_type       d2_item_ff, d2_item_in;
   logic [COUNT_W-1:0]   diff;
   logic [SHIFT_W-1:0]   right_amount;

   assign enable   = !d2_valid_ff || !queue_full;
   assign in_ready = enable;

   always_comb begin
      diff         = in_reading - cfg.stamp_value;
      d1_valid_in  = in_valid;
      d1_delta_in  = diff >> RATE_SHIFT;
      d1_behind_in = (in_reading <= cfg.stamp_value);
   end

   // A negative code shifts right by its magnitude; minus 64 clears the value.
   always_comb begin
      right_amount = SHIFT_W'(-cfg.scale_shift);
      d2_valid_in  = d1_valid_ff;
      d2_item_in.behind = d1_behind_ff;
      if (cfg.scale_shift[SHIFT_W-1] == 1'b0) begin
         d2_item_in.scaled = d1_delta_ff << cfg.scale_shift[SHIFT_W-2:0];
      end else begin
         d2_item_in.scaled = d1_delta_ff >> right_amount;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
      end else if (enable) begin
         d1_valid_ff <= d1_valid_in;
         d2_valid_ff <= d2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d1_delta_ff  <= d1_delta_in;
         d1_behind_ff <= d1_behind_in;
         d2_item_ff   <= d2_item_in;
      end
   end

   assign queue_ctl.push = d2_valid_ff && !queue_full;
   assign queue_ctl.full = queue_full;
   assign queue_item     = d2_item_ff;

endmodule : pvts_front
`default_nettype wire

FILE: hw/rtl/pvts_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pvts_queue: short queue between the front and back halves
// A small circular buffer that lets either half stall without stopping the
// other.
// -----------------------------------------------------------------------------
module pvts_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire pvts_pkg::queue_ctl_type push_ctl,
   input  wire pvts_pkg::front_item_type push_item,
   output logic                         full,
   input  wire                          pop,
   output logic                         empty,
   output pvts_pkg::front_item_type     pop_item
);
   import pvts_pkg::*;

   front_item_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push_ctl.push && !push_ctl.full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule : pvts_queue
`default_nettype wire

FILE: hw/rtl/pvts_back.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pvts_back: multiply, sum, clamp and offset stages
// Four register stages ending in the result register. The whole half moves
// together and stops only while a result waits to be taken.
// -----------------------------------------------------------------------------
module pvts_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire pvts_pkg::cfg_type       cfg,
   input  wire                          queue_empty,
   input  wire pvts_pkg::front_item_type queue_item,
   output logic                         queue_pop,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [pvts_pkg::COUNT_W-1:0] out_count,
   output logic                         out_clamped,
   output logic                         out_behind
);
   import pvts_pkg::*;

   logic                 enable;

   // Multiply stage.
   logic                 m_valid_ff;
   logic [FRAC_W-1:0]    m_lo_top_ff, m_lo_top_in;
   logic [COUNT_W-1:0]   m_hi_prod_ff, m_hi_prod_in;
   logic                 m_behind_ff;
   logic [COUNT_W-1:0]   lo_prod;

   // Sum stage.
   logic                 s_valid_ff;
   logic [COUNT_W-1:0]   s_time_ff, s_time_in;
   logic                 s_behind_ff;

   // Clamp stage.
   logic                 c_valid_ff;
   logic [COUNT_W-1:0]   c_chosen_ff, c_chosen_in;
   logic                 c_clamped_ff, c_clamped_in;
   logic                 c_behind_ff;
   logic [COUNT_W-1:0]   max_ff, max_in;

   // Result register.
   logic                 o_valid_ff;
   logic [COUNT_W-1:0]   o_count_ff;
   logic                 o_clamped_ff;
   logic                 o_behind_ff;

   assign enable    = !o_valid_ff || out_ready;
   assign queue_pop = enable && !queue_empty;

   always_comb begin
      lo_prod      = COUNT_W'(queue_item.scaled[FRAC_W-1:0]) * COUNT_W'(cfg.scale_fraction);
      m_lo_top_in  = lo_prod[COUNT_W-1:FRAC_W];
      m_hi_prod_in = COUNT_W'(queue_item.scaled[COUNT_W-1:FRAC_W])
                     * COUNT_W'(cfg.scale_fraction);
   end

   assign s_time_in = COUNT_W'(m_lo_top_ff) + m_hi_prod_ff
                      + (cfg.reference_time >> RATE_SHIFT);

   // A time equal to the kept maximum counts as clamped.
   always_comb begin
      max_in       = max_ff;
      c_chosen_in  = s_time_ff;
      c_clamped_in = 1'b0;
      if (!cfg.no_clamp) begin
         if (s_time_ff <= max_ff) begin
            c_chosen_in  = max_ff;
            c_clamped_in = 1'b1;
         end else begin
            max_in = s_time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         max_ff     <= '0;
      end else if (enable) begin
         m_valid_ff <= !queue_empty;
         s_valid_ff <= m_valid_ff;
         c_valid_ff <= s_valid_ff;
         o_valid_ff <= c_valid_ff;
         if (s_valid_ff) begin
            max_ff <= max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         m_lo_top_ff  <= m_lo_top_in;
         m_hi_prod_ff <= m_hi_prod_in;
         m_behind_ff  <= queue_item.behind;
         s_time_ff    <= s_time_in;
         s_behind_ff  <= m_behind_ff;
         c_chosen_ff  <= c_chosen_in;
         c_clamped_ff <= c_clamped_in;
         c_behind_ff  <= s_behind_ff;
         o_count_ff   <= c_chosen_ff + cfg.offset_base;
         o_clamped_ff <= c_clamped_ff;
         o_behind_ff  <= c_behind_ff;
      end
   end

   assign out_valid   = o_valid_ff;
   assign out_count   = o_count_ff;
   assign out_clamped = o_clamped_ff;
   assign out_behind  = o_behind_ff;

endmodule : pvts_back
`default_nettype wire

FILE: hw/rtl/pvclock_tsc_to_time_scaler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pvclock_tsc_to_time_scaler_unit: counter reading to system time
// Converts raw 64-bit counter readings into system time and returns one result
// per reading, in order. One reading can be taken every clock cycle while the
// queue is not full. Two front stages (delta and pre-shift) feed a four-entry
// queue, from which four back stages (multiply, sum, clamp, offset) drain; the
// clamp stage compares against and updates the kept maximum in the same cycle,
// so readings follow one another without gaps. The user must write registers
// through the csr port only while no reading is in flight; the block itself
// does not enforce this.
// -----------------------------------------------------------------------------
module pvclock_tsc_to_time_scaler_unit (
   input  wire                              clock,
   input  wire                              reset,
   // Configuration writes.
   input  wire                              csr_we,
   input  wire [pvts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [pvts_pkg::COUNT_W-1:0]      csr_wdata,
   // Counter readings.
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [63:0]                       req_tdata,  // [63:0] counter_reading
   // Results.
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [63:0]                      rsp_tdata,  // [63:0] system_count
   output logic [1:0]                       rsp_tuser   // [0] was_clamped, [1] behind_stamp
);
   import pvts_pkg::*;

   logic [COUNT_W-1:0]        stamp_value_ff;
   logic [COUNT_W-1:0]        reference_time_ff;
   logic [FRAC_W-1:0]         scale_fraction_ff;
   logic signed [SHIFT_W-1:0] scale_shift_ff;
   logic                      stable_ff;
   logic [COUNT_W-1:0]        offset_base_ff;
   logic                      single_cpu_ff;
   cfg_type                   cfg;

   queue_ctl_type             queue_ctl;
   front_item_type            push_item;
   front_item_type            pop_item;
   logic                      queue_full;
   logic                      queue_empty;
   logic                      queue_pop;
   logic                      rsp_clamped;
   logic                      rsp_behind;

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_value_ff    <= '0;
         reference_time_ff <= '0;
         scale_fraction_ff <= '0;
         scale_shift_ff    <= '0;
         stable_ff         <= 1'b0;
         offset_base_ff    <= '0;
         single_cpu_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STAMP_VALUE:    stamp_value_ff    <= csr_wdata;
            CSR_REFERENCE_TIME: reference_time_ff <= csr_wdata;
            CSR_SCALE_FRACTION: scale_fraction_ff <= csr_wdata[FRAC_W-1:0];
            CSR_SCALE_SHIFT:    scale_shift_ff    <= csr_wdata[SHIFT_W-1:0];
            CSR_CLOCK_FLAGS:    stable_ff         <= csr_wdata[STABLE_BIT];
            CSR_OFFSET_BASE:    offset_base_ff    <= csr_wdata;
            CSR_SINGLE_CPU:     single_cpu_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.stamp_value    = stamp_value_ff;
      cfg.reference_time = reference_time_ff;
      cfg.scale_fraction = scale_fraction_ff;
      cfg.scale_shift    = scale_shift_ff;
      cfg.no_clamp       = stable_ff || single_cpu_ff;
      cfg.offset_base    = offset_base_ff;
   end

   pvts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_reading (req_tdata),
      .queue_full (queue_full),
      .queue_ctl  (queue_ctl),
      .queue_item (push_item)
   );

   pvts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_ctl  (queue_ctl),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .pop_item  (pop_item)
   );

   pvts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (queue_empty),
      .queue_item  (pop_item),
      .queue_pop   (queue_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_count   (rsp_tdata),
      .out_clamped (rsp_clamped),
      .out_behind  (rsp_behind)
   );

   assign rsp_tuser = {rsp_behind, rsp_clamped};

endmodule : pvclock_tsc_to_time_scaler_unit
`default_nettype wire

FILE: hw/rtl/pvts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pvts_checker: port-level checks of the scaler
// Tracks transfers on both channels and checks stall hold and clamp behavior.
// -----------------------------------------------------------------------------
module pvts_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire [2:0]   csr_index,
   input  wire [63:0]  csr_wdata,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire [63:0]  req_tdata,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire [63:0]  rsp_tdata,
   input  wire [1:0]   rsp_tuser
);
   logic [7:0]  pending_ff;
   logic        last_clamped_ff;
   logic [63:0] last_count_ff;
   logic        req_xfer, rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff      <= '0;
         last_clamped_ff <= 1'b0;
      end else begin
         pending_ff <= pending_ff + 8'(req_xfer) - 8'(rsp_xfer);
         if (csr_we) begin
            last_clamped_ff <= 1'b0;
         end else if (rsp_xfer) begin
            last_clamped_ff <= rsp_tuser[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer) begin
         last_count_ff <= rsp_tdata;
      end
   end

   // A held result keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No result without a reading waiting for it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 8'd0)
      else $error("result without a pending reading");

   // An empty block always takes a reading.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 8'd0 |-> req_tready)
      else $error("reading refused while idle");

   // Back-to-back clamped results return the same kept maximum.
   a_clamp_same: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_tuser[0] && last_clamped_ff && !csr_we |-> rsp_tdata == last_count_ff)
      else $error("clamped results disagree");

   // Ports that only complete the bind connection.
   logic unused_ok;
   assign unused_ok = ^{csr_index, csr_wdata, req_tdata};

endmodule : pvts_checker

bind pvclock_tsc_to_time_scaler_unit pvts_checker u_pvts_checker (.*);
`default_nettype wire
